FILE: rtl/sha512_pkg.sv
`default_nettype none
package sha512_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PAD_NONE,
      PAD_PAD,
      PAD_ZERO,
      PAD_LEN
   } pad_type;

   localparam int ROUNDS     = 80;
   localparam logic [3:0] LEN_HI_SLOT = 4'd14;

   localparam logic [63:0] ROUND_K [ROUNDS] = '{
      64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
      64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
      64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
      64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
      64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
      64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
      64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
      64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
      64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
      64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
      64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
      64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
      64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
      64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
      64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
      64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
      64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
      64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
      64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
      64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
   };

   localparam logic [63:0] INIT_H [8] = '{
      64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
      64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F, 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
   };

   function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] big_sigma0(input logic [63:0] x);
      big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic logic [63:0] big_sigma1(input logic [63:0] x);
      big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

   function automatic logic [63:0] small_sigma0(input logic [63:0] x);
      small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic logic [63:0] small_sigma1(input logic [63:0] x);
      small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   function automatic logic [63:0] ch(input logic [63:0] e, input logic [63:0] f,
                                      input logic [63:0] g);
      ch = (e & f) ^ (~e & g);
   endfunction

   function automatic logic [63:0] maj(input logic [63:0] a, input logic [63:0] b,
                                       input logic [63:0] c);
      maj = (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/sha512_hash_engine.sv
// A word that does not complete a block is only stored; one that completes a block
// starts 80 rounds and then a fold. A last word adds up to two padded blocks
// and then eight digest transfers, one per cycle while rsp_ready is high.
// Blocks are hashed one at a time by the single round unit; req_ready is low until idle.
// Reset (synchronous, active high) loads the initial hash values and clears the counts.
`default_nettype none
module sha512_hash_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_message_word,
   input  wire logic [3:0]  req_valid_bytes,
   input  wire logic        req_last_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_digest_done
);

   sha512_pkg::state_type state_ff, state_in;
   sha512_pkg::pad_type   pad_ff, pad_in;

   logic [63:0] h_ff [8];
   logic [63:0] v_ff [8];
   logic [63:0] w_ff [16];        // sliding schedule window
   logic [3:0]  fill_ff;
   logic [6:0]  round_ff;
   logic [2:0]  out_ff;
   logic [63:0] cnt_lo_ff, cnt_hi_ff;
   logic [63:0] push_word;
   logic        push_en;

   logic        accept;
   logic [3:0]  nb;
   logic [63:0] mask, padw, wt, wnew, t1, t2;
   logic [64:0] lo_sum;

   assign accept = req_valid && req_ready;
   assign nb = (req_valid_bytes > 4'd8) ? 4'd8 : req_valid_bytes;
   assign mask = (nb == 4'd0) ? 64'd0 : ~64'd0 << (7'd64 - {nb, 3'b000});
   assign padw = (req_message_word & mask) | (64'h80 << (6'd56 - {nb[2:0], 3'b000}));
   assign lo_sum = {1'b0, cnt_lo_ff} +
                   {61'd0, (req_last_of_message ? nb : 4'd8)};

   // schedule: rounds 0..15 use the window head directly
   assign wt   = w_ff[0];
   assign wnew = sha512_pkg::small_sigma1(w_ff[14]) + w_ff[9]
               + sha512_pkg::small_sigma0(w_ff[1]) + w_ff[0];
   assign t1 = v_ff[7] + sha512_pkg::big_sigma1(v_ff[4])
             + sha512_pkg::ch(v_ff[4], v_ff[5], v_ff[6])
             + sha512_pkg::ROUND_K[round_ff] + wt;
   assign t2 = sha512_pkg::big_sigma0(v_ff[0]) + sha512_pkg::maj(v_ff[0], v_ff[1], v_ff[2]);

   always_comb begin
      push_en   = 1'b0;
      push_word = 64'd0;
      case (state_ff)
         sha512_pkg::ST_IDLE: begin
            if (accept && (!req_last_of_message || nb == 4'd8)) begin
               push_en   = 1'b1;
               push_word = req_message_word;
            end else if (accept) begin
               push_en   = 1'b1;
               push_word = padw;
            end
         end
         sha512_pkg::ST_PUSH: begin
            push_en = 1'b1;
            case (pad_ff)
               sha512_pkg::PAD_PAD:  push_word = 64'h8000000000000000;
               sha512_pkg::PAD_LEN:  push_word = (fill_ff == sha512_pkg::LEN_HI_SLOT)
                                       ? {cnt_hi_ff[60:0], cnt_lo_ff[63:61]}
                                       : {cnt_lo_ff[60:0], 3'b000};
               default:              push_word = 64'd0;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pad_in   = pad_ff;
      case (state_ff)
         sha512_pkg::ST_IDLE: begin
            if (accept) begin
               if (!req_last_of_message) pad_in = sha512_pkg::PAD_NONE;
               else if (nb == 4'd8) pad_in = sha512_pkg::PAD_PAD;
               else pad_in = (fill_ff == 4'd13) ? sha512_pkg::PAD_LEN : sha512_pkg::PAD_ZERO;
               if (fill_ff == 4'd15) state_in = sha512_pkg::ST_ROUND;
               else if (req_last_of_message) state_in = sha512_pkg::ST_PUSH;
            end
         end
         sha512_pkg::ST_PUSH: begin
            if (pad_ff == sha512_pkg::PAD_PAD)
               pad_in = (fill_ff == 4'd13) ? sha512_pkg::PAD_LEN : sha512_pkg::PAD_ZERO;
            else if (pad_ff == sha512_pkg::PAD_ZERO && fill_ff == 4'd13)
               pad_in = sha512_pkg::PAD_LEN;
            if (fill_ff == 4'd15) state_in = sha512_pkg::ST_ROUND;
         end
         sha512_pkg::ST_ROUND: begin
            if (round_ff == 7'(sha512_pkg::ROUNDS - 1)) state_in = sha512_pkg::ST_FOLD;
         end
         sha512_pkg::ST_FOLD: begin
            // a length word in slot 15 ends the message
            if (pad_ff == sha512_pkg::PAD_LEN) state_in = sha512_pkg::ST_OUT;
            else if (pad_ff == sha512_pkg::PAD_NONE) state_in = sha512_pkg::ST_IDLE;
            else state_in = sha512_pkg::ST_PUSH;
         end
         sha512_pkg::ST_OUT: begin
            if (rsp_ready && out_ff == 3'd7) state_in = sha512_pkg::ST_IDLE;
         end
         default: state_in = sha512_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = (state_ff == sha512_pkg::ST_IDLE);
      rsp_valid       = (state_ff == sha512_pkg::ST_OUT);
      rsp_digest_word = h_ff[out_ff];
      rsp_word_index  = out_ff;
      rsp_digest_done = (out_ff == 3'd7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sha512_pkg::ST_IDLE;
         pad_ff    <= sha512_pkg::PAD_NONE;
         fill_ff   <= 4'd0;
         round_ff  <= 7'd0;
         out_ff    <= 3'd0;
         cnt_lo_ff <= 64'd0;
         cnt_hi_ff <= 64'd0;
         for (int i = 0; i < 8; i++) h_ff[i] <= sha512_pkg::INIT_H[i];
      end else begin
         state_ff <= state_in;
         pad_ff   <= pad_in;
         if (accept) begin
            cnt_lo_ff <= lo_sum[63:0];
            cnt_hi_ff <= cnt_hi_ff + {63'd0, lo_sum[64]};
         end
         if (push_en) begin
            fill_ff <= fill_ff + 4'd1;
            if (fill_ff == 4'd15) begin
               round_ff <= 7'd0;
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
            end
         end
         if (state_ff == sha512_pkg::ST_ROUND) begin
            round_ff <= round_ff + 7'd1;
            v_ff[7] <= v_ff[6];
            v_ff[6] <= v_ff[5];
            v_ff[5] <= v_ff[4];
            v_ff[4] <= v_ff[3] + t1;
            v_ff[3] <= v_ff[2];
            v_ff[2] <= v_ff[1];
            v_ff[1] <= v_ff[0];
            v_ff[0] <= t1 + t2;
         end
         if (state_ff == sha512_pkg::ST_FOLD) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         end
         if (state_ff == sha512_pkg::ST_OUT && rsp_ready) begin
            out_ff <= out_ff + 3'd1;
            if (out_ff == 3'd7) begin
               cnt_lo_ff <= 64'd0;
               cnt_hi_ff <= 64'd0;
               fill_ff   <= 4'd0;
               for (int i = 0; i < 8; i++) h_ff[i] <= sha512_pkg::INIT_H[i];
            end
         end
      end
   end

   // schedule window: filled in order, then slid once per round
   always_ff @(posedge clock) begin
      if (push_en) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= push_word;
      end else if (state_ff == sha512_pkg::ST_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= wnew;
      end
   end

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
   } msg_item_type;

   typedef struct packed {
      logic [63:0] word;
      logic [2:0]  index;
      logic        done;
   } digest_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_message_word = '0;
   logic [3:0]  req_valid_bytes = '0;
   logic        req_last_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_digest_done;

   sha512_hash_engine dut (.*);

   always #2 clock = ~clock;

   msg_item_type    pending_words[$];
   digest_item_type expected_digests[$];
   int           error_count = 0;
   int           words_sent = 0;
   int           digests_seen = 0;
   int           messages_done = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   bit           hold_send = 1'b0;
   bit           req_accepted = 1'b0;

   // predictor state
   logic [63:0]  chain[8];
   logic [63:0]  blk[16];
   logic [3:0]   fill;
   logic [127:0] nbytes_total;

   function automatic logic [63:0] ror(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   task automatic hash_init();
      chain = sha512_pkg::INIT_H;
      foreach (blk[i]) blk[i] = '0;
      fill = '0;
      nbytes_total = '0;
   endtask

   task automatic compress();
      logic [63:0] w[80];
      logic [63:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 80; i++)
         w[i] = (ror(w[i-2], 19) ^ ror(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7]
              + (ror(w[i-15], 1) ^ ror(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
      {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                  chain[4], chain[5], chain[6], chain[7]};
      for (int i = 0; i < 80; i++) begin
         t1 = h + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41)) + ((e & f) ^ (~e & g))
            + sha512_pkg::ROUND_K[i] + w[i];
         t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
   endtask

   task automatic load_word(logic [63:0] w);
      blk[fill] = w;
      fill = fill + 1'b1;
      if (fill == 0) compress();
   endtask

   task automatic predict_digest(msg_item_type it);
      int unsigned n;
      logic [63:0] pad, mask;
      digest_item_type r;
      if (!it.last) begin
         nbytes_total += 8;
         load_word(it.word);
         return;
      end
      n = (it.nbytes > 8) ? 8 : it.nbytes;
      nbytes_total += n;
      if (n == 8) begin
         load_word(it.word);
         pad = 64'h8000_0000_0000_0000;
      end else begin
         mask = (n == 0) ? 64'h0 : ~64'h0 << (64 - 8 * n);
         pad = (it.word & mask) | (64'h80 << (56 - 8 * n));
      end
      load_word(pad);
      while (fill != 4'd14) load_word(64'h0);
      load_word(nbytes_total[124:61]);
      load_word({nbytes_total[60:0], 3'b000});
      for (int j = 0; j < 8; j++) begin
         r.word = chain[j];
         r.index = j[2:0];
         r.done = (j == 7);
         expected_digests.push_back(r);
      end
      hash_init();
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h (digest word %0d)",
               what, got, want, digests_seen);
      error_count++;
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_accepted) begin
            if (pending_words.size() > 0 && !hold_send
                && $urandom_range(99) >= send_idle_pct) begin
               msg_item_type it;
               it = pending_words.pop_front();
               req_valid <= 1'b1;
               req_message_word <= it.word;
               req_valid_bytes <= it.nbytes;
               req_last_of_message <= it.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      req_accepted <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            msg_item_type it;
            it = '{req_message_word, req_valid_bytes, req_last_of_message};
            predict_digest(it);
            words_sent++;
            if (it.last) messages_done++;
         end
         if (rsp_valid && rsp_ready) begin
            digest_item_type exp_d;
            if (expected_digests.size() == 0) begin
               report("unexpected digest transfer", rsp_digest_word, 64'h0);
            end else begin
               exp_d = expected_digests.pop_front();
               if (rsp_digest_word !== exp_d.word)
                  report("digest_word", rsp_digest_word, exp_d.word);
               if (rsp_word_index !== exp_d.index)
                  report("word_index", rsp_word_index, exp_d.index);
               if (rsp_digest_done !== exp_d.done)
                  report("digest_done", rsp_digest_done, exp_d.done);
            end
            digests_seen++;
         end
      end
   end

   function automatic logic [63:0] rand_word();
      logic [63:0] w;
      case ($urandom_range(5))
         0: w = '0;
         1: w = '1;
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   task automatic queue_message(int nwords, logic [3:0] tail_bytes, logic [63:0] tail_word);
      for (int i = 0; i < nwords; i++)
         pending_words.push_back('{rand_word(), 4'($urandom_range(15)), 1'b0});
      pending_words.push_back('{tail_word, tail_bytes, 1'b1});
   endtask

   task automatic queue_random_message();
      int nw;
      logic [3:0] nb;
      // short messages, boundary lengths 13..16 words and random lengths up to 32 words
      case ($urandom_range(3))
         0: nw = $urandom_range(0, 3);
         1: nw = $urandom_range(13, 16);
         default: nw = $urandom_range(0, 32);
      endcase
      nb = ($urandom_range(4) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
      queue_message(nw, nb, rand_word());
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || req_valid || expected_digests.size() > 0)
         @(posedge clock);
   endtask

   task automatic drain_expected();
      while (req_valid || expected_digests.size() > 0) @(posedge clock);
   endtask

   initial begin
      hash_init();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty message, valid_bytes 0..8 and an oversize 15, full-block boundaries
      send_idle_pct = 0;
      recv_stall_pct = 0;
      queue_message(0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_message(0, 4'd3, 64'h6162_6300_0000_0000);
      queue_message(0, 4'd8, '1);
      queue_message(0, 4'd15, 64'h0123_4567_89AB_CDEF);
      queue_message(13, 4'd7, '1);
      queue_message(14, 4'd8, '0);
      queue_message(15, 4'd0, '1);
      for (int i = 1; i < 8; i++) queue_message(0, 4'(i), {$urandom, $urandom});
      drain();

      // hold the next message back until every digest has come out
      queue_message(2, 4'd5, rand_word());
      while (pending_words.size() > 0) @(posedge clock);
      hold_send = 1'b1;
      queue_message(1, 4'd6, rand_word());
      drain_expected();
      hold_send = 1'b0;
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         int base;
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 73 : 27) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 73 : 27) : 0;
         base = words_sent;
         while (words_sent + pending_words.size() - base < 8) queue_random_message();
         drain();
      end
      repeat (200) @(posedge clock);

      $display("sent %0d message words in %0d messages, checked %0d digest words",
               words_sent, messages_done, digests_seen);
      $display("covered empty, partial and oversize tails, block boundaries and stalls");
      if (error_count == 0 && expected_digests.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule

FILE: sim.f
rtl/sha512_pkg.sv
rtl/sha512_hash_engine.sv
bench/tb_top.sv
